@@ src/assert_macros.svh @@
// Assertion macros shared by the packet framer RTL.
// Included by every module that carries concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define B64PF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("framer assertion failed");

// Next-cycle implication, disabled while reset is high.
`define B64PF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("framer assertion failed");

`endif

@@ src/b64pf_pkg.sv @@
// Package for the base64 packet framer: constants, register and job types, helpers.
// Used by every module of the framer; depends on nothing else.
`default_nettype none

package b64pf_pkg;

   localparam int HEADER_MAX      = 8;
   localparam int QUEUE_DEPTH_DEF = 4;

   // Character slots of one job, emitted in ascending order.
   localparam int P_FULL  = HEADER_MAX;
   localparam int P_FNL   = HEADER_MAX + 4;
   localparam int P_PART  = HEADER_MAX + 5;
   localparam int P_END   = HEADER_MAX + 9;
   localparam int P_ERR   = HEADER_MAX + 10;
   localparam int MASK_W  = HEADER_MAX + 11;
   localparam int POS_W   = $clog2(MASK_W);
   localparam int HDR_IDX_W = (HEADER_MAX > 1) ? $clog2(HEADER_MAX) : 1;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   localparam logic [7:0]  CHAR_NL         = 8'h0a;
   localparam logic [7:0]  CHAR_PAD        = 8'h3d;
   localparam logic [7:0]  CHAR_NONE       = 8'h00;
   localparam logic [7:0]  LINE_WIDTH_RST  = 8'd76;
   localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1024;

   typedef enum logic [1:0] {
      REG_HEADER_CHARS = 2'd0,
      REG_HEADER_COUNT = 2'd1,
      REG_LINE_WIDTH   = 2'd2,
      REG_MAX_PAYLOAD  = 2'd3
   } reg_index_type;

   typedef enum logic {
      CMD_BEGIN = 1'b0,
      CMD_BYTE  = 1'b1
   } command_type;

   typedef struct packed {
      logic [63:0] header_chars;
      logic [3:0]  header_count;
      logic [7:0]  line_width;
      logic [15:0] max_payload;
   } cfg_type;

   typedef struct packed {
      logic [MASK_W-1:0] mask;
      logic [23:0]       full_bytes;
      logic [15:0]       part_bytes;
      logic              part_two;
   } job_type;

   typedef struct packed {
      logic        full;
      logic [23:0] full_bytes;
      logic [23:0] bytes;
      logic [1:0]  fill;
   } feed_type;

   function automatic feed_type feed_byte(input logic [23:0] bytes, input logic [1:0] fill,
                                          input logic [7:0] b);
      feed_type r;
      r.full       = 1'b0;
      r.full_bytes = bytes;
      r.bytes      = bytes;
      r.fill       = fill;
      case (fill)
         2'd0: begin
            r.bytes = {b, 16'h0000};
            r.fill  = 2'd1;
         end
         2'd1: begin
            r.bytes = {bytes[23:16], b, 8'h00};
            r.fill  = 2'd2;
         end
         2'd2: begin
            r.full       = 1'b1;
            r.full_bytes = {bytes[23:8], b};
            r.bytes      = 24'h000000;
            r.fill       = 2'd0;
         end
         default: begin
            r.fill = fill;
         end
      endcase
      return r;
   endfunction

   function automatic logic [7:0] b64_char(input logic [5:0] v);
      logic [7:0] w;
      logic [7:0] c;
      w = {2'b00, v};
      if (v < 6'd26) begin
         c = w + 8'd65;
      end else if (v < 6'd52) begin
         c = w + 8'd71;
      end else if (v < 6'd62) begin
         c = w - 8'd4;
      end else if (v == 6'd62) begin
         c = 8'h2b;
      end else begin
         c = 8'h2f;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ src/b64pf_csr.sv @@
// Configuration registers of the packet framer behind an APB-style port.
// Depends on b64pf_pkg for the register index codes and the cfg_type bundle.
`default_nettype none

module b64pf_csr (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 psel,
   input  wire                                 penable,
   input  wire                                 pwrite,
   input  wire  [b64pf_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire  [b64pf_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [b64pf_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                pready,
   output b64pf_pkg::cfg_type                  cfg
);
   import b64pf_pkg::*;

   logic [63:0]   header_chars_ff, header_chars_in;
   logic [3:0]    header_count_ff, header_count_in;
   logic [7:0]    line_width_ff, line_width_in;
   logic [15:0]   max_payload_ff, max_payload_in;
   logic          wr_en;
   reg_index_type sel;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite & pready;
   assign sel    = reg_index_type'(paddr[4:3]);

   always_comb begin
      header_chars_in = header_chars_ff;
      header_count_in = header_count_ff;
      line_width_in   = line_width_ff;
      max_payload_in  = max_payload_ff;
      if (wr_en) begin
         case (sel)
            REG_HEADER_CHARS: header_chars_in = pwdata;
            REG_HEADER_COUNT: header_count_in = pwdata[3:0];
            REG_LINE_WIDTH:   line_width_in   = pwdata[7:0];
            REG_MAX_PAYLOAD:  max_payload_in  = pwdata[15:0];
            default:          header_chars_in = header_chars_ff;
         endcase
      end
   end

   always_comb begin
      case (sel)
         REG_HEADER_CHARS: prdata = header_chars_ff;
         REG_HEADER_COUNT: prdata = {60'h0, header_count_ff};
         REG_LINE_WIDTH:   prdata = {56'h0, line_width_ff};
         REG_MAX_PAYLOAD:  prdata = {48'h0, max_payload_ff};
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_chars_ff <= '0;
         header_count_ff <= '0;
         line_width_ff   <= LINE_WIDTH_RST;
         max_payload_ff  <= MAX_PAYLOAD_RST;
      end else begin
         header_chars_ff <= header_chars_in;
         header_count_ff <= header_count_in;
         line_width_ff   <= line_width_in;
         max_payload_ff  <= max_payload_in;
      end
   end

   assign cfg.header_chars = header_chars_ff;
   assign cfg.header_count = header_count_ff;
   assign cfg.line_width   = line_width_ff;
   assign cfg.max_payload  = max_payload_ff;

endmodule

`default_nettype wire

@@ src/b64pf_front.sv @@
// Front end of the framer: accepts items, tracks packet and quantum state, builds jobs.
// Depends on b64pf_pkg for the job layout, feed helper and configuration bundle.
`default_nettype none

`include "assert_macros.svh"

module b64pf_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire                  req_command,
   input  wire  [7:0]           req_payload_byte,
   input  wire  [15:0]          req_packet_length,
   input  b64pf_pkg::cfg_type   cfg,
   input  wire                  queue_full,
   output logic                 push_valid,
   output b64pf_pkg::job_type   push_job
);
   import b64pf_pkg::*;

   logic [23:0] qbytes_ff, qbytes_in;
   logic [1:0]  fill_ff, fill_in;
   logic [15:0] sum_ff, sum_in;
   logic [15:0] left_ff, left_in;
   logic [7:0]  line_ff, line_in;
   logic        open_ff, open_in;

   logic                  accept;
   logic [3:0]            hc;
   logic [HEADER_MAX-1:0] hdr_mask;
   logic [15:0]           sum_next;
   logic [15:0]           left_next;
   logic                  finishing;
   feed_type              s1, s2, s3;
   logic [8:0]            hdr_lc;
   logic [8:0]            byte_lc;
   logic                  hdr_nl;
   logic                  byte_nl;
   logic                  byte_full;
   logic [23:0]           byte_full_bytes;
   job_type               job;

   assign req_stall = queue_full;
   assign accept    = req_valid & ~queue_full;

   assign hc = (cfg.header_count > 4'(HEADER_MAX)) ? 4'(HEADER_MAX) : cfg.header_count;

   always_comb begin
      for (int i = 0; i < HEADER_MAX; i++) begin
         hdr_mask[i] = (4'(i) < hc);
      end
   end

   assign sum_next  = sum_ff + {8'h00, req_payload_byte};
   assign left_next = left_ff - 16'd1;
   assign finishing = (left_next == 16'd0);

   assign s1 = feed_byte(qbytes_ff, fill_ff, req_payload_byte);
   assign s2 = feed_byte(s1.bytes, s1.fill, sum_next[15:8]);
   assign s3 = feed_byte(s2.bytes, s2.fill, sum_next[7:0]);

   assign byte_full = s1.full | (finishing & (s2.full | s3.full));
   assign byte_full_bytes = s1.full ? s1.full_bytes :
                            (s2.full ? s2.full_bytes : s3.full_bytes);

   assign hdr_lc  = {5'b0, hc} + 9'd4;
   assign byte_lc = {1'b0, line_ff} + 9'd4;
   assign hdr_nl  = (hdr_lc >= {1'b0, cfg.line_width});
   assign byte_nl = (byte_lc >= {1'b0, cfg.line_width});

   always_comb begin
      qbytes_in = qbytes_ff;
      fill_in   = fill_ff;
      sum_in    = sum_ff;
      left_in   = left_ff;
      line_in   = line_ff;
      open_in   = open_ff;
      job       = '0;
      if (accept) begin
         if (command_type'(req_command) == CMD_BEGIN) begin
            qbytes_in = '0;
            fill_in   = '0;
            sum_in    = '0;
            left_in   = '0;
            line_in   = '0;
            open_in   = 1'b0;
            if (req_packet_length > cfg.max_payload) begin
               job.mask[P_ERR] = 1'b1;
            end else begin
               job.mask[HEADER_MAX-1:0] = hdr_mask;
               if (req_packet_length == 16'd0) begin
                  job.mask[P_FULL +: 4] = 4'hf;
                  job.mask[P_FNL]       = hdr_nl;
                  job.mask[P_PART +: 4] = 4'hf;
                  job.mask[P_END]       = 1'b1;
               end else begin
                  qbytes_in = {req_packet_length, 8'h00};
                  fill_in   = 2'd2;
                  line_in   = {4'b0, hc};
                  left_in   = req_packet_length;
                  open_in   = 1'b1;
               end
            end
         end else if (open_ff) begin
            job.full_bytes = byte_full_bytes;
            if (byte_full) begin
               job.mask[P_FULL +: 4] = 4'hf;
               job.mask[P_FNL]       = byte_nl;
               line_in               = byte_nl ? 8'd0 : byte_lc[7:0];
            end
            if (finishing) begin
               job.part_bytes = s3.bytes[23:8];
               job.part_two   = (s3.fill == 2'd2);
               if (s3.fill != 2'd0) begin
                  job.mask[P_PART +: 4] = 4'hf;
               end
               job.mask[P_END] = 1'b1;
               qbytes_in = '0;
               fill_in   = '0;
               sum_in    = '0;
               left_in   = '0;
               line_in   = '0;
               open_in   = 1'b0;
            end else begin
               qbytes_in = s1.bytes;
               fill_in   = s1.fill;
               sum_in    = sum_next;
               left_in   = left_next;
            end
         end
      end
   end

   assign push_valid = accept & (|job.mask);
   assign push_job   = job;

   always_ff @(posedge clock) begin
      if (reset) begin
         qbytes_ff <= '0;
         fill_ff   <= '0;
         sum_ff    <= '0;
         left_ff   <= '0;
         line_ff   <= '0;
         open_ff   <= 1'b0;
      end else begin
         qbytes_ff <= qbytes_in;
         fill_ff   <= fill_in;
         sum_ff    <= sum_in;
         left_ff   <= left_in;
         line_ff   <= line_in;
         open_ff   <= open_in;
      end
   end

   `B64PF_ASSERT_IMPL(a_open_fill, clock, reset, open_ff, (fill_ff != 2'd3) && (left_ff != 16'd0))
   `B64PF_ASSERT_IMPL(a_idle_clear, clock, reset, !open_ff, ({fill_ff, left_ff, sum_ff} == '0))

endmodule

`default_nettype wire

@@ src/b64pf_queue.sv @@
// Short job queue between the front end and the character emitter.
// Depends on b64pf_pkg for job_type; depth comes from the DEPTH parameter.
`default_nettype none

`include "assert_macros.svh"

module b64pf_queue #(
   parameter int DEPTH = b64pf_pkg::QUEUE_DEPTH_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  b64pf_pkg::job_type   push_job,
   output logic                 full,
   input  wire                  pop,
   output logic                 pop_valid,
   output b64pf_pkg::job_type   pop_job
);
   import b64pf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wptr_ff, wptr_in;
   logic [PTR_W-1:0]   rptr_ff, rptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign do_push   = push & ~full;
   assign do_pop    = pop & pop_valid;
   assign pop_job   = entry_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   `B64PF_ASSERT_IMPL(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))

endmodule

`default_nettype wire

@@ src/b64pf_back.sv @@
// Framer's character emitter: walks job slot masks, one character a cycle unless stalled.
// Depends on b64pf_pkg for slot positions, the job layout and the base64 alphabet.
`default_nettype none

`include "assert_macros.svh"

module b64pf_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire  [63:0]          header_chars,
   input  wire                  q_valid,
   input  b64pf_pkg::job_type   q_job,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output logic [7:0]           rsp_out_char,
   output logic                 rsp_last_of_run,
   output logic                 rsp_packet_end,
   output logic                 rsp_too_long
);
   import b64pf_pkg::*;

   logic [MASK_W-1:0] mask_ff, mask_in;
   logic [23:0]       full_ff;
   logic [15:0]       part_ff;
   logic              two_ff;

   logic              valid_ff, valid_in;
   logic [7:0]        char_ff;
   logic              last_ff;
   logic              pend_ff;
   logic              err_ff;

   logic [POS_W-1:0]  pos;
   logic [POS_W-1:0]  rel_full;
   logic [POS_W-1:0]  rel_part;
   logic [MASK_W-1:0] rest;
   logic              have;
   logic              out_free;
   logic              emit;
   logic              last;
   logic [7:0]        ch;
   logic [7:0]        hdr [HEADER_MAX];
   logic [5:0]        fsym [4];

   always_comb begin
      pos = '0;
      for (int i = MASK_W - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            pos = POS_W'(i);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < HEADER_MAX; i++) begin
         hdr[i] = header_chars[63 - 8 * i -: 8];
      end
      for (int k = 0; k < 4; k++) begin
         fsym[k] = full_ff[23 - 6 * k -: 6];
      end
   end

   assign rel_full = pos - POS_W'(P_FULL);
   assign rel_part = pos - POS_W'(P_PART);

   always_comb begin
      if (pos < POS_W'(P_FULL)) begin
         ch = hdr[pos[HDR_IDX_W-1:0]];
      end else if (pos < POS_W'(P_FNL)) begin
         ch = b64_char(fsym[rel_full[1:0]]);
      end else if (pos == POS_W'(P_FNL)) begin
         ch = CHAR_NL;
      end else if (pos < POS_W'(P_END)) begin
         case (rel_part[1:0])
            2'd0:    ch = b64_char(part_ff[15:10]);
            2'd1:    ch = b64_char(part_ff[9:4]);
            2'd2:    ch = two_ff ? b64_char({part_ff[3:0], 2'b00}) : CHAR_PAD;
            default: ch = CHAR_PAD;
         endcase
      end else if (pos == POS_W'(P_END)) begin
         ch = CHAR_NL;
      end else begin
         ch = CHAR_NONE;
      end
   end

   assign rest     = mask_ff & (mask_ff - MASK_W'(1));
   assign have     = |mask_ff;
   assign out_free = ~valid_ff | ~rsp_stall;
   assign emit     = have & out_free;
   assign last     = (rest == '0);
   assign q_pop    = q_valid & (~have | (emit & last));

   always_comb begin
      mask_in = mask_ff;
      if (q_pop) begin
         mask_in = q_job.mask;
      end else if (emit) begin
         mask_in = rest;
      end
      valid_in = valid_ff;
      if (out_free) begin
         valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         mask_ff  <= mask_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         full_ff <= q_job.full_bytes;
         part_ff <= q_job.part_bytes;
         two_ff  <= q_job.part_two;
      end
      if (emit) begin
         char_ff <= ch;
         last_ff <= last;
         pend_ff <= (pos == POS_W'(P_END));
         err_ff  <= (pos == POS_W'(P_ERR));
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_char    = char_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_packet_end  = pend_ff;
   assign rsp_too_long    = err_ff;

   `B64PF_ASSERT_IMPL(a_end_is_last, clock, reset, valid_ff && (pend_ff || err_ff), last_ff)
   `B64PF_ASSERT_NEXT(a_emit_shows, clock, reset, have && out_free, valid_ff)

endmodule

`default_nettype wire

@@ src/base64_packet_framer_top.sv @@
// Top level of the base64 packet framer: register port, front end, job queue, emitter.
// Depends on b64pf_pkg and the b64pf_csr, b64pf_front, b64pf_queue and b64pf_back modules.
`default_nettype none

// The framer accepts one input transfer per cycle while its job queue, QUEUE_DEPTH entries
// deep, has room; each accepted begin or payload transfer becomes at most one job in that
// cycle. The emitter delivers at most one character per cycle: an idle emitter first loads
// a job from the queue, and it then walks queued jobs without gaps while results are not
// stalled. A payload byte yields no character, four base64 characters, five with an
// inserted newline, or up to ten when it closes the packet, about 1.33 on average, so a
// byte stream, with its newlines, is limited by the single character path of the emitter; a
// begin costs up to eighteen characters. While results stall, the queue keeps taking jobs,
// and the input stalls only once the queue is full.

module base64_packet_framer_top #(
   parameter int QUEUE_DEPTH = b64pf_pkg::QUEUE_DEPTH_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire                               req_command,
   input  wire  [7:0]                        req_payload_byte,
   input  wire  [15:0]                       req_packet_length,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic [7:0]                        rsp_out_char,
   output logic                              rsp_last_of_run,
   output logic                              rsp_packet_end,
   output logic                              rsp_too_long,
   input  wire                               csr_psel,
   input  wire                               csr_penable,
   input  wire                               csr_pwrite,
   input  wire  [b64pf_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire  [b64pf_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [b64pf_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                              csr_pready
);
   import b64pf_pkg::*;

   cfg_type cfg;
   logic    push_valid;
   job_type push_job;
   logic    queue_full;
   logic    q_pop;
   logic    q_valid;
   job_type q_job;

   b64pf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   b64pf_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_payload_byte  (req_payload_byte),
      .req_packet_length (req_packet_length),
      .cfg               (cfg),
      .queue_full        (queue_full),
      .push_valid        (push_valid),
      .push_job          (push_job)
   );

   b64pf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_job  (push_job),
      .full      (queue_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_job   (q_job)
   );

   b64pf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .header_chars    (cfg.header_chars),
      .q_valid         (q_valid),
      .q_job           (q_job),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_packet_end  (rsp_packet_end),
      .rsp_too_long    (rsp_too_long)
   );

endmodule

`default_nettype wire
